@@ rtl/gh_pkg.sv @@
// Shared types, codes and helper functions for the GHASH accumulator.
`timescale 1ns / 1ps

package gh_pkg;

   // Field widths
   localparam int BlockW   = 128;
   localparam int HalfW    = 64;
   localparam int CountW   = 61;
   localparam int NBytesW  = 5;
   localparam int FuncW    = 2;
   localparam int CsrIdxW  = 1;
   localparam int ReqDataW = 136;   // data_hi, data_lo, valid_bytes, zero fill
   localparam int RspDataW = 128;   // digest_hi, digest_lo

   typedef logic [BlockW-1:0]  block_type;
   typedef logic [HalfW-1:0]   half_type;
   typedef logic [CountW-1:0]  count_type;
   typedef logic [NBytesW-1:0] nbytes_type;

   // Function codes carried in req_tuser
   localparam logic [FuncW-1:0] FUNC_AAD    = 2'd0;
   localparam logic [FuncW-1:0] FUNC_TEXT   = 2'd1;
   localparam logic [FuncW-1:0] FUNC_FINISH = 2'd2;

   // Register indexes on the csr port
   localparam logic [CsrIdxW-1:0] CSR_KEY_HI = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_KEY_LO = 1'd1;

   // Full block size in bytes
   localparam nbytes_type BLOCK_BYTES = 5'd16;

   // Reverse bit order: GCM bit 0 is the top bit of byte 0.
   function automatic block_type gh_bitrev(input block_type v);
      block_type r;
      for (int i = 0; i < BlockW; i++) begin
         r[i] = v[BlockW-1-i];
      end
      return r;
   endfunction

   // Keep the leading n bytes of the block (byte 0 in the top bits), zero the rest.
   function automatic block_type gh_mask_block(input block_type blk, input nbytes_type n);
      block_type r;
      for (int k = 0; k < 16; k++) begin
         r[BlockW-1-8*k -: 8] = (NBytesW'(k) < n) ? blk[BlockW-1-8*k -: 8] : 8'h00;
      end
      return r;
   endfunction

endpackage

@@ rtl/gh_gfmul.sv @@
// GF(2^128) multiplier in GCM bit order, reduction by x^128 + x^7 + x^2 + x + 1.
`timescale 1ns / 1ps

module gh_gfmul (
   input  gh_pkg::block_type x,
   input  gh_pkg::block_type h,
   output gh_pkg::block_type z
);
   import gh_pkg::*;

   block_type           a;
   block_type           b;
   logic [2*BlockW-2:0] prod;
   logic [BlockW-2:0]   prod_hi;
   logic [BlockW+5:0]   fold1;
   logic [5:0]          fold1_hi;
   block_type           fold2;

   // Polynomial form: coefficient of x^i sits in bit i
   assign a = gh_bitrev(x);
   assign b = gh_bitrev(h);

   // Carry-less product, each bit an XOR over its partial-product diagonal
   always_comb begin
      block_type terms;
      for (int i = 0; i < 2*BlockW-1; i++) begin
         for (int j = 0; j < BlockW; j++) begin
            if ((i - j >= 0) && (i - j < BlockW)) begin
               terms[j] = a[j] & b[i-j];
            end else begin
               terms[j] = 1'b0;
            end
         end
         prod[i] = ^terms;
      end
   end

   // First fold: x^128 = x^7 + x^2 + x + 1, leaves up to degree 133
   assign prod_hi = prod[2*BlockW-2:BlockW];
   assign fold1   = {6'b0, prod[BlockW-1:0]}
                  ^ {7'b0, prod_hi}
                  ^ {6'b0, prod_hi, 1'b0}
                  ^ {5'b0, prod_hi, 2'b0}
                  ^ {prod_hi, 7'b0};

   // Second fold of the six overflow bits
   assign fold1_hi = fold1[BlockW+5:BlockW];
   assign fold2    = fold1[BlockW-1:0]
                   ^ {122'b0, fold1_hi}
                   ^ {121'b0, fold1_hi, 1'b0}
                   ^ {120'b0, fold1_hi, 2'b0}
                   ^ {115'b0, fold1_hi, 7'b0};

   // Back to GCM bit order
   assign z = gh_bitrev(fold2);

endmodule

@@ rtl/ghash_accumulator.sv @@
// GHASH accumulator top level: input register, GF(2^128) execute step, result register.
`timescale 1ns / 1ps

// The block takes one transaction per clock cycle, back to back, as long as the
// result side keeps up. An absorb transaction (associated data or ciphertext)
// is registered in the input register and then XORed into the accumulator and
// multiplied by H combinationally; the combinational GF(2^128) multiply in
// the accumulator feedback path is what sets the one-transaction-per-cycle rate.
// A finish transaction in the input register waits for the result register to
// be free, then folds in the length block, loads the digest into the result
// register, which raises rsp_tvalid, and clears the accumulator and both byte
// counts. Only finish waits on rsp_tready; absorbs keep flowing while a
// digest sits unread. Write the hash key (csr index 0 high half, 1 low half)
// while no transaction is in flight; the key resets to zero.

module ghash_accumulator (
   input  logic                          clock,
   input  logic                          reset,
   // request stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [gh_pkg::ReqDataW-1:0]   req_tdata,  // data_hi, data_lo, valid_bytes, zero fill
   input  logic [gh_pkg::FuncW-1:0]      req_tuser,  // func
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [gh_pkg::RspDataW-1:0]   rsp_tdata,  // digest_hi, digest_lo
   // configuration writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gh_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [gh_pkg::HalfW-1:0]      csr_data
);
   import gh_pkg::*;

   // Key and running state
   half_type   key_hi_ff,   key_hi_in;
   half_type   key_lo_ff,   key_lo_in;
   block_type  acc_ff,      acc_in;
   count_type  aad_cnt_ff,  aad_cnt_in;
   count_type  text_cnt_ff, text_cnt_in;

   // Input register
   logic             s1_valid_ff, s1_valid_in;
   logic [FuncW-1:0] s1_func_ff;
   block_type        s1_blk_ff;
   nbytes_type       s1_nbytes_ff;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   block_type  rsp_digest_ff;

   // Execute step
   logic       rsp_free;
   logic       s1_finish;
   logic       s1_absorb;
   logic       exec_fire;
   logic       absorb_go;
   logic       finish_go;
   logic       req_accept;
   nbytes_type nbytes_clamped;
   block_type  blk_masked;
   block_type  len_block;
   block_type  mul_x;
   block_type  mul_z;

   // Handshake control
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s1_finish  = (s1_func_ff == FUNC_FINISH);
   assign s1_absorb  = (s1_func_ff == FUNC_AAD) || (s1_func_ff == FUNC_TEXT);
   assign exec_fire  = s1_valid_ff && (!s1_finish || rsp_free);
   assign req_tready = !s1_valid_ff || exec_fire;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign absorb_go  = exec_fire && s1_absorb && (s1_nbytes_ff != '0);
   assign finish_go  = exec_fire && s1_finish;

   // Block masking and length block
   assign nbytes_clamped = (s1_nbytes_ff > BLOCK_BYTES) ? BLOCK_BYTES : s1_nbytes_ff;
   assign blk_masked     = gh_mask_block(s1_blk_ff, nbytes_clamped);
   assign len_block      = {aad_cnt_ff, 3'b000, text_cnt_ff, 3'b000};
   assign mul_x          = acc_ff ^ (s1_finish ? len_block : blk_masked);

   gh_gfmul u_gfmul (
      .x (mul_x),
      .h ({key_hi_ff, key_lo_ff}),
      .z (mul_z)
   );

   // Next-state logic
   always_comb begin
      key_hi_in   = key_hi_ff;
      key_lo_in   = key_lo_ff;
      acc_in      = acc_ff;
      aad_cnt_in  = aad_cnt_ff;
      text_cnt_in = text_cnt_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KEY_HI: key_hi_in = csr_data;
            CSR_KEY_LO: key_lo_in = csr_data;
            default:    ;
         endcase
      end

      if (absorb_go) begin
         acc_in = mul_z;
         if (s1_func_ff == FUNC_AAD) begin
            aad_cnt_in = aad_cnt_ff + {56'd0, nbytes_clamped};
         end else begin
            text_cnt_in = text_cnt_ff + {56'd0, nbytes_clamped};
         end
      end else if (finish_go) begin
         acc_in      = '0;
         aad_cnt_in  = '0;
         text_cnt_in = '0;
      end

      // input register occupancy
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (exec_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      // result register occupancy
      if (finish_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff    <= '0;
         key_lo_ff    <= '0;
         acc_ff       <= '0;
         aad_cnt_ff   <= '0;
         text_cnt_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_hi_ff    <= key_hi_in;
         key_lo_ff    <= key_lo_in;
         acc_ff       <= acc_in;
         aad_cnt_ff   <= aad_cnt_in;
         text_cnt_ff  <= text_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_func_ff   <= req_tuser;
         s1_blk_ff    <= {req_tdata[HalfW-1:0], req_tdata[2*HalfW-1:HalfW]};
         s1_nbytes_ff <= req_tdata[2*HalfW+NBytesW-1:2*HalfW];
      end
      if (finish_go) begin
         rsp_digest_ff <= mul_z;
      end
   end

   // Outputs: digest_hi in the low half of tdata
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_digest_ff[HalfW-1:0], rsp_digest_ff[BlockW-1:HalfW]};

endmodule

@@ rtl/gh_checker.sv @@
// Port-level checks for the GHASH accumulator, bound to the top level.
`timescale 1ns / 1ps

module gh_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic [gh_pkg::FuncW-1:0]      req_tuser,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [gh_pkg::RspDataW-1:0]   rsp_tdata
);
   import gh_pkg::*;

   // A stalled digest holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("digest changed or dropped while stalled");

   // Reset leaves no result pending
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A fresh digest comes from an accepted finish transaction
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && (req_tuser == FUNC_FINISH), 2))
      else $error("digest without a matching finish transaction");

   // Requests only stall behind an unread digest
   a_req_flow: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("request stalled while result side is free");

endmodule

bind ghash_accumulator gh_checker u_gh_checker (.*);
